FILE: src/lbk_pkg.sv
package lbk_pkg;

    // Default number of rounds
    localparam int ROUND_COUNT_DEF = 32;

    localparam int HALF_W      = 32;
    localparam int KEY_HI_W    = 64;
    localparam int KEY_LO_W    = 16;
    localparam int KEY_W       = KEY_HI_W + KEY_LO_W;
    localparam int RND_W       = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Key register rotation amount
    localparam int KEY_ROT = 29;

    // Register reset values
    localparam logic [RND_W-1:0]  FAULT_ROUND_RST = 5'd28;
    localparam logic [HALF_W-1:0] FAULT_MASK_RST  = 32'hffff_ffff;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_UPPER   = 3'd0,
        CFG_KEY_LOWER   = 3'd1,
        CFG_FAULT_ROUND = 3'd2,
        CFG_FAULT_MASK  = 3'd3
    } lbk_cfg_idx_t;

    // Data travelling down the round pipeline
    typedef struct packed {
        logic [HALF_W-1:0]   xl;
        logic [HALF_W-1:0]   xr;
        logic [KEY_HI_W-1:0] hi;
        logic [KEY_LO_W-1:0] lo;
    } lbk_state_t;

    // Fault injection controls handed to every stage
    typedef struct packed {
        logic [RND_W-1:0]  round;
        logic [HALF_W-1:0] mask;
    } lbk_fault_t;

    // Round S-boxes, S0 on nibble 0 up to S7 on nibble 7
    localparam logic [3:0] SB_ROUND [8][16] = '{
        '{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
          4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
        '{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
          4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
        '{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
          4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
        '{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
          4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
        '{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
          4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
        '{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
          4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
        '{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
          4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
        '{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
          4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6}
    };

    // Key schedule S-boxes
    localparam logic [3:0] SB_KEY8 [16] = '{
        4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
        4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3
    };
    localparam logic [3:0] SB_KEY9 [16] = '{
        4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
        4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6
    };

    // Eight parallel 4-bit substitutions
    function automatic logic [HALF_W-1:0] subst(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] res;
        res = '0;
        for (int n = 0; n < 8; n++) begin
            res[4*n +: 4] = SB_ROUND[n][v[4*n +: 4]];
        end
        return res;
    endfunction

    // Nibble permutation
    function automatic logic [HALF_W-1:0] permute(input logic [HALF_W-1:0] v);
        return ((v >> 4) & 32'h000f_000f) | ((v << 4) & 32'hf000_f000)
             | ((v >> 8) & 32'h00f0_00f0) | ((v << 8) & 32'h0f00_0f00);
    endfunction

    // One key register update: rotate, two S-boxes, counter XOR
    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                    input logic [RND_W-1:0] count);
        logic [KEY_W-1:0] r;
        r = {k[KEY_W-KEY_ROT-1:0], k[KEY_W-1:KEY_W-KEY_ROT]};
        r[79:76] = SB_KEY9[r[79:76]];
        r[75:72] = SB_KEY8[r[75:72]];
        r[50:46] = r[50:46] ^ count;
        return r;
    endfunction

endpackage

FILE: src/lblock_encrypt_with_fault_mask_core.sv
// Throughput: one item per cycle when nothing stalls; each pipeline stage does one
// Feistel round, and every stage but the first also one key update.
// Stalls propagate back stage by stage; empty stages still take items while output waits.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the config registers:
// key zero, fault round 28, fault mask all ones.
module lblock_encrypt_with_fault_mask_core
    import lbk_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [HALF_W-1:0]      plain_left,
    input  logic [HALF_W-1:0]      plain_right,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [HALF_W-1:0]      cipher_left,
    output logic [HALF_W-1:0]      cipher_right,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [KEY_HI_W-1:0] key_hi;
    logic [KEY_LO_W-1:0] key_lo;
    lbk_fault_t          fault;

    logic       s_valid [ROUND_COUNT+1];
    logic       s_ready [ROUND_COUNT+1];
    lbk_state_t s_data  [ROUND_COUNT+1];

    // Configuration registers
    lbk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_hi    (key_hi),
        .key_lo    (key_lo),
        .fault     (fault)
    );

    // Pipeline head: plaintext plus master key
    assign s_valid[0]   = in_valid;
    assign in_ready     = s_ready[0];
    assign s_data[0].xl = plain_left;
    assign s_data[0].xr = plain_right;
    assign s_data[0].hi = key_hi;
    assign s_data[0].lo = key_lo;

    // Round stages
    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_round
        lbk_round #(
            .ROUND_IDX (i),
            .LAST      ((i == ROUND_COUNT - 1) ? 1 : 0)
        ) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (s_valid[i]),
            .up_ready (s_ready[i]),
            .up_data  (s_data[i]),
            .dn_valid (s_valid[i+1]),
            .dn_ready (s_ready[i+1]),
            .dn_data  (s_data[i+1]),
            .fault    (fault)
        );
    end

    // Pipeline tail
    assign out_valid              = s_valid[ROUND_COUNT];
    assign s_ready[ROUND_COUNT]   = out_ready;
    assign cipher_left            = s_data[ROUND_COUNT].xl;
    assign cipher_right           = s_data[ROUND_COUNT].xr;

endmodule

FILE: src/lbk_cfg.sv
module lbk_cfg
    import lbk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [KEY_HI_W-1:0]    key_hi,
    output logic [KEY_LO_W-1:0]    key_lo,
    output lbk_fault_t             fault
);

    logic [KEY_HI_W-1:0] key_hi_reg;
    logic [KEY_LO_W-1:0] key_lo_reg;
    logic [RND_W-1:0]    fault_round_reg;
    logic [HALF_W-1:0]   fault_mask_reg;

    // Writes are always accepted
    assign cfg_ready = 1'b1;

    // Register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg      <= '0;
            key_lo_reg      <= '0;
            fault_round_reg <= FAULT_ROUND_RST;
            fault_mask_reg  <= FAULT_MASK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_UPPER:   key_hi_reg      <= cfg_data;
                CFG_KEY_LOWER:   key_lo_reg      <= cfg_data[KEY_LO_W-1:0];
                CFG_FAULT_ROUND: fault_round_reg <= cfg_data[RND_W-1:0];
                CFG_FAULT_MASK:  fault_mask_reg  <= cfg_data[HALF_W-1:0];
                default:         ;
            endcase
        end
    end

    assign key_hi      = key_hi_reg;
    assign key_lo      = key_lo_reg;
    assign fault.round = fault_round_reg;
    assign fault.mask  = fault_mask_reg;

endmodule

FILE: src/lbk_round.sv
module lbk_round
    import lbk_pkg::*;
#(
    parameter int ROUND_IDX = 0,
    parameter int LAST      = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  lbk_state_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output lbk_state_t dn_data,
    input  lbk_fault_t fault
);

    localparam logic [RND_W-1:0] IDX_CODE = RND_W'(ROUND_IDX);

    logic       valid_reg;
    lbk_state_t data_reg;
    lbk_state_t data_next;

    // Stage takes an item when empty or when its item moves on
    assign up_ready = !valid_reg || dn_ready;

    // One Feistel round, after one key update in every stage but the first
    always_comb
    begin
        logic [KEY_W-1:0]  k;
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] r;
        k = {up_data.hi, up_data.lo};
        if (ROUND_IDX != 0)
        begin
            k = key_update(k, IDX_CODE);
        end
        x = up_data.xl ^ k[KEY_W-1:KEY_W-HALF_W];
        if (fault.round == IDX_CODE)
        begin
            x = x & fault.mask;
        end
        r = {up_data.xr[HALF_W-9:0], up_data.xr[HALF_W-1:HALF_W-8]} ^ permute(subst(x));
        data_next.hi = k[KEY_W-1:KEY_LO_W];
        data_next.lo = k[KEY_LO_W-1:0];
        if (LAST != 0)
        begin
            data_next.xl = up_data.xl;
            data_next.xr = r;
        end
        else
        begin
            data_next.xl = r;
            data_next.xr = up_data.xl;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/lbk_checker.sv
module lbk_checker
    import lbk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_ready,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [HALF_W-1:0]      cipher_left,
    input  logic [HALF_W-1:0]      cipher_right,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cipher_left) && $stable(cipher_right))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // With the last stage empty the whole pipeline can take an item
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    // Config writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind lblock_encrypt_with_fault_mask_core lbk_checker u_lbk_checker (.*);

FILE: sim/tb.sv
module tb;
    import lbk_pkg::*;

    localparam int ROUNDS = ROUND_COUNT_DEF;

    // Spare register indexes: writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_LO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam int RAND_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_PHASE      = 3;
    localparam int PAUSE_PHASE     = 6;
    localparam int HOLD_CYCLES     = 300;

    // S-box tables, entry 0 in the leftmost nibble
    localparam logic [0:511] SBOX_F = {
        64'hE9F0_D4AB_1283_76C5, 64'h4BE9_FD0A_7C56_2813,
        64'h1E7C_FD06_B593_248A, 64'h768B_0F3E_9ACD_5241,
        64'hE5F0_72CD_1849_BA63, 64'h2DBC_FE09_7A63_1845,
        64'hB94E_0FAD_6C57_3812, 64'hDAF0_E49B_2183_75C6
    };
    localparam logic [0:63] SBOX_K8 = 64'h87E5_FD06_BC9A_2413;
    localparam logic [0:63] SBOX_K9 = 64'hB5F0_729D_481C_EA36;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t              kind;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   wdata;
        logic [HALF_W-1:0]       left;
        logic [HALF_W-1:0]       right;
    } dir_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [HALF_W-1:0]      plain_left;
    logic [HALF_W-1:0]      plain_right;
    logic                   out_valid;
    logic                   out_ready;
    logic [HALF_W-1:0]      cipher_left;
    logic [HALF_W-1:0]      cipher_right;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the configuration registers
    logic [KEY_HI_W-1:0] key_hi;
    logic [KEY_LO_W-1:0] key_lo;
    logic [RND_W-1:0]    flt_round;
    logic [HALF_W-1:0]   flt_mask;

    logic [2*HALF_W-1:0] cipher_due[$];
    dir_step_t           dir_steps[$];
    int                  failures;
    int                  hold_len;
    bit                  src_fast;
    bit                  sink_fast;

    lblock_encrypt_with_fault_mask_core #(.ROUND_COUNT(ROUNDS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .plain_left   (plain_left),
        .plain_right  (plain_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cipher_left  (cipher_left),
        .cipher_right (cipher_right),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Eight round S-boxes then the nibble permutation
    function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] s;
        for (int n = 0; n < 8; n++)
        begin
            s[4*n +: 4] = SBOX_F[(64*n + 4*v[4*n +: 4]) +: 4];
        end
        return ((s >> 4) & 32'h000f_000f) | ((s << 4) & 32'hf000_f000)
             | ((s >> 8) & 32'h00f0_00f0) | ((s << 8) & 32'h0f00_0f00);
    endfunction

    // Key register step: rotate left 29, S-box the top two nibbles, mix in the count
    function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
                                                  input logic [RND_W-1:0] cnt);
        logic [KEY_W-1:0] r;
        r = {k[50:0], k[79:51]};
        r[79:76] = SBOX_K9[4*r[79:76] +: 4];
        r[75:72] = SBOX_K8[4*r[75:72] +: 4];
        r[50:46] = r[50:46] ^ cnt;
        return r;
    endfunction

    // Full encryption under the current shadow registers
    function automatic logic [2*HALF_W-1:0] lblock_encrypt(input logic [HALF_W-1:0] l,
                                                           input logic [HALF_W-1:0] r);
        logic [KEY_W-1:0]  k;
        logic [HALF_W-1:0] xl;
        logic [HALF_W-1:0] xr;
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] t;
        k  = {key_hi, key_lo};
        xl = l;
        xr = r;
        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            if (rnd != 0)
                k = next_key(k, rnd[RND_W-1:0]);
            xr = {xr[23:0], xr[31:24]};
            x  = xl ^ k[79:48];
            if (rnd == int'(flt_round))
                x = x & flt_mask;
            xr = xr ^ round_fn(x);
            if (rnd != ROUNDS - 1)
            begin
                t  = xl;
                xl = xr;
                xr = t;
            end
        end
        return {xl, xr};
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_item(input logic [HALF_W-1:0] l, input logic [HALF_W-1:0] r);
        dir_step_t s;
        s = '{kind: STEP_ITEM, reg_idx: '0, wdata: '0, left: l, right: r};
        dir_steps.push_back(s);
    endfunction

    function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
        dir_step_t s;
        s = '{kind: STEP_CFG, reg_idx: idx, wdata: d, left: '0, right: '0};
        dir_steps.push_back(s);
    endfunction

    // Offer one item; entered and left at a falling edge, valid left high
    task automatic send_block(input logic [HALF_W-1:0] l, input logic [HALF_W-1:0] r);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        plain_left  = l;
        plain_right = r;
        do @(posedge clk); while (in_ready !== 1'b1);
        cipher_due.push_back(lblock_encrypt(l, r));
        @(negedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        in_valid = 1'b0;
        wait (cipher_due.size() == 0);
        @(negedge clk);
    endtask

    // One register write; the shadow copy follows at the accepting edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_KEY_UPPER:   key_hi    = d;
            CFG_KEY_LOWER:   key_lo    = d[KEY_LO_W-1:0];
            CFG_FAULT_ROUND: flt_round = d[RND_W-1:0];
            CFG_FAULT_MASK:  flt_mask  = d[HALF_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // New random setting; upper data bits carry junk that must be dropped
    task automatic pick_config();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 3))
            0: d = '0;
            1: d = '1;
            default: d = {$urandom, $urandom};
        endcase
        write_reg(CFG_KEY_UPPER, d);
        write_reg(CFG_KEY_LOWER, {$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: d = {$urandom, $urandom} & ~64'h1f;
            1: d = {$urandom, $urandom} | 64'h1f;
            default: d = {$urandom, $urandom};
        endcase
        write_reg(CFG_FAULT_ROUND, d);
        case ($urandom_range(0, 3))
            0: d = {$urandom, 32'hffff_ffff};
            1: d = {$urandom, 32'h0};
            2: d = {$urandom, ~(32'h1 << $urandom_range(0, 31))};
            default: d = {$urandom, $urandom};
        endcase
        write_reg(CFG_FAULT_MASK, d);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                      {$urandom, $urandom});
    endtask

    // Result side: random stalls, long hold-off on request, in-order check
    initial
    begin : sink
        logic [2*HALF_W-1:0] due;
        int gap;
        int taken;
        out_ready = 1'b0;
        sink_fast = 1'b0;
        taken     = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            if (taken % 64 == 0)
                sink_fast = ($urandom_range(0, 3) == 0);
            gap = sink_fast ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            taken++;
            if (cipher_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected item: left=%h right=%h", cipher_left, cipher_right);
            end
            else
            begin
                due = cipher_due.pop_front();
                if (cipher_left !== due[63:32] || cipher_right !== due[31:0])
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: expected left=%h right=%h, got left=%h right=%h",
                                 due[63:32], due[31:0], cipher_left, cipher_right);
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        dir_step_t s;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        plain_left  = '0;
        plain_right = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_KEY_UPPER;
        cfg_data    = '0;
        failures    = 0;
        hold_len    = 0;
        src_fast    = 1'b0;
        key_hi      = '0;
        key_lo      = '0;
        flt_round   = FAULT_ROUND_RST;
        flt_mask    = FAULT_MASK_RST;

        // Reset values: zero key, no fault
        add_item(32'h0000_0000, 32'h0000_0000);
        add_item(32'hffff_ffff, 32'hffff_ffff);
        add_item(32'hffff_ffff, 32'h0000_0000);
        add_item(32'h0000_0000, 32'hffff_ffff);
        add_item(32'haaaa_aaaa, 32'h5555_5555);
        // All-ones key, junk above the lower key field
        add_cfg(CFG_KEY_UPPER, 64'hffff_ffff_ffff_ffff);
        add_cfg(CFG_KEY_LOWER, 64'hffff_ffff_ffff_ffff);
        add_item(32'h0000_0000, 32'h0000_0000);
        add_item(32'h0123_4567, 32'h89ab_cdef);
        // Fault in the first round with everything masked off
        add_cfg(CFG_FAULT_ROUND, 64'hffff_ffff_ffff_ffe0);
        add_cfg(CFG_FAULT_MASK, 64'hffff_ffff_0000_0000);
        add_item(32'h0000_0000, 32'h0000_0000);
        add_item(32'hffff_ffff, 32'hffff_ffff);
        // Fault in the last round, half mask
        add_cfg(CFG_FAULT_ROUND, 64'h0000_0000_0000_001f);
        add_cfg(CFG_FAULT_MASK, 64'h1234_5678_0000_ffff);
        add_item(32'h1234_5678, 32'h9abc_def0);
        add_item(32'hffff_ffff, 32'h0000_0000);
        // Spare indexes must leave the setting alone
        add_cfg(CFG_IDX_SPARE_LO, 64'h0);
        add_cfg(CFG_IDX_SPARE_HI, 64'hffff_ffff_ffff_ffff);
        add_item(32'h0000_0000, 32'h0000_0000);
        // Zero key, fault disabled by an all-ones mask
        add_cfg(CFG_KEY_UPPER, 64'h0);
        add_cfg(CFG_KEY_LOWER, 64'h0);
        add_cfg(CFG_FAULT_ROUND, 64'd28);
        add_cfg(CFG_FAULT_MASK, 64'h0000_0000_ffff_ffff);
        add_item(32'h8000_0000, 32'h0000_0001);
        add_item(32'h0000_0001, 32'h8000_0000);
        // Mixed key, single mask bit cleared mid-way
        add_cfg(CFG_KEY_UPPER, 64'h0123_4567_89ab_cdef);
        add_cfg(CFG_KEY_LOWER, 64'h0000_0000_0000_fedc);
        add_cfg(CFG_FAULT_ROUND, 64'd15);
        add_cfg(CFG_FAULT_MASK, 64'h0000_0000_ffff_fffe);
        add_item(32'hdead_beef, 32'hcafe_f00d);
        add_item(32'hffff_ffff, 32'hffff_ffff);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part
        foreach (dir_steps[i])
        begin
            s = dir_steps[i];
            if (s.kind == STEP_CFG)
            begin
                drain();
                write_reg(s.reg_idx, s.wdata);
            end
            else
            begin
                send_block(s.left, s.right);
            end
        end

        // Random part, one setting per phase
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            pick_config();
            src_fast = ($urandom_range(0, 2) == 0);
            if (ph == HOLD_PHASE)
            begin
                // Receiver stops for a long stretch while items keep coming
                src_fast = 1'b1;
                hold_len = HOLD_CYCLES;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    drain();
                if (n % 40 == 39)
                    src_fast = ($urandom_range(0, 2) == 0);
                send_block(rand_half(), rand_half());
            end
        end

        drain();
        repeat (ROUNDS + 8) @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
